FILE: src/daily_extrema_convergence_check_top_assert.svh
// Assertion macros used by the daily extrema convergence check RTL
`ifndef DAILY_EXTREMA_CONVERGENCE_CHECK_TOP_ASSERT_SVH
`define DAILY_EXTREMA_CONVERGENCE_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define DCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dcc_pkg.sv
// Types, register map and constants of the daily extrema convergence check
package dcc_pkg;

    localparam int MAX_CHANNELS_DEF = 256;
    localparam int PADDR_W          = 4;
    localparam int PDATA_W          = 32;

    localparam logic [1:0] REG_TOLERANCE     = 2'd0;
    localparam logic [1:0] REG_MAX_WARMUP    = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [15:0] TOLERANCE_RST     = 16'd26;
    localparam logic [11:0] MAX_WARMUP_RST    = 12'd25;
    localparam logic [8:0]  CHANNEL_COUNT_RST = 9'd256;

    localparam logic [1:0] OUTCOME_LIMIT     = 2'd0;
    localparam logic [1:0] OUTCOME_CONTINUE  = 2'd1;
    localparam logic [1:0] OUTCOME_CONVERGED = 2'd2;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [7:0]         channel;
        logic signed [15:0] temperature;
        logic               begin_day;
        logic               warmup_active;
        logic [11:0]        day_number;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [11:0] restored_day;
    } t_out_word;

    typedef struct packed {
        logic [15:0] tolerance;
        logic [11:0] max_warmup_days;
        logic [8:0]  channel_count;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] day_max;
        logic signed [15:0] day_min;
        logic signed [15:0] prior_max;
        logic signed [15:0] prior_min;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SAMPLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

FILE: src/dcc_cfg.sv
// APB configuration registers of the daily extrema convergence check
module dcc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dcc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dcc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dcc_pkg::PDATA_W-1:0]  prdata,
    output dcc_pkg::t_cfg                o_cfg
);
    import dcc_pkg::*;

    t_cfg r_cfg;
    logic wr_acc;

    assign wr_acc = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance       <= TOLERANCE_RST;
            r_cfg.max_warmup_days <= MAX_WARMUP_RST;
            r_cfg.channel_count   <= CHANNEL_COUNT_RST;
        end else if (wr_acc) begin
            unique case (paddr[3:2])
                REG_TOLERANCE:     r_cfg.tolerance       <= pwdata[15:0];
                REG_MAX_WARMUP:    r_cfg.max_warmup_days <= pwdata[11:0];
                REG_CHANNEL_COUNT: r_cfg.channel_count   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TOLERANCE:     prdata = {16'd0, r_cfg.tolerance};
            REG_MAX_WARMUP:    prdata = {20'd0, r_cfg.max_warmup_days};
            REG_CHANNEL_COUNT: prdata = {23'd0, r_cfg.channel_count};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/dcc_ram.sv
// Extrema store: one write port, one registered read port
module dcc_ram #(
    parameter int DEPTH = dcc_pkg::MAX_CHANNELS_DEF,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  dcc_pkg::t_entry  i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output dcc_pkg::t_entry  o_rd_data
);
    import dcc_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/dcc_cmp.sv
// Tolerance test of one extremum against the previous day's value
module dcc_cmp (
    input  logic signed [15:0] i_now,
    input  logic signed [15:0] i_prior,
    input  logic [15:0]        i_tol,
    output logic               o_ok
);
    logic signed [17:0] diff;
    logic signed [17:0] tol;

    assign diff = 18'(i_now) - 18'(i_prior);
    assign tol  = $signed({2'b00, i_tol});
    assign o_ok = (diff <= tol) && (diff >= -tol);

endmodule

FILE: src/dcc_ctrl.sv
// Sequencer: clear pass, sample read-modify-write, channel scan, result register
`include "daily_extrema_convergence_check_top_assert.svh"
module dcc_ctrl #(
    parameter int MAX_CHANNELS = dcc_pkg::MAX_CHANNELS_DEF,
    parameter int AW           = 8,
    parameter int CW           = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dcc_pkg::t_cfg       i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dcc_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dcc_pkg::t_out_word  o_out_word,
    output logic [AW-1:0]       o_rd_addr,
    input  dcc_pkg::t_entry     i_rd_data,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output dcc_pkg::t_entry     o_wr_data
);
    import dcc_pkg::*;

    t_state    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_n, n_n;
    logic      r_pend, n_pend;
    logic      r_fail, n_fail;
    logic [11:0] r_last_day, n_last_day;
    logic      r_smp_ok, n_smp_ok;
    logic [AW-1:0] r_smp_addr, n_smp_addr;
    logic signed [15:0] r_smp_temp, n_smp_temp;
    logic      r_smp_begin, n_smp_begin;
    t_out_word r_res, n_res;
    logic      r_out_vld, n_out_vld;
    t_out_word r_out, n_out;

    logic [12:0] ch13;
    logic [12:0] cnt13;
    logic [12:0] n13;
    logic      in_acc;
    logic      issue;
    logic      ok_max, ok_min;
    t_entry    upd;

    assign ch13   = 13'(i_in_word.channel);
    assign cnt13  = 13'(i_cfg.channel_count);
    assign n13    = (cnt13 > 13'(MAX_CHANNELS)) ? 13'(MAX_CHANNELS) : cnt13;
    assign in_acc = i_in_valid && o_in_ready;
    assign issue  = (r_idx < r_n);

    dcc_cmp u_cmp_max (
        .i_now   (i_rd_data.day_max),
        .i_prior (i_rd_data.prior_max),
        .i_tol   (i_cfg.tolerance),
        .o_ok    (ok_max)
    );

    dcc_cmp u_cmp_min (
        .i_now   (i_rd_data.day_min),
        .i_prior (i_rd_data.prior_min),
        .i_tol   (i_cfg.tolerance),
        .o_ok    (ok_min)
    );

    always_comb begin
        upd = i_rd_data;
        if (r_smp_begin) begin
            upd.prior_max = i_rd_data.day_max;
            upd.prior_min = i_rd_data.day_min;
            upd.day_max   = r_smp_temp;
            upd.day_min   = r_smp_temp;
        end else begin
            if (r_smp_temp > i_rd_data.day_max) begin
                upd.day_max = r_smp_temp;
            end
            if (r_smp_temp < i_rd_data.day_min) begin
                upd.day_min = r_smp_temp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_last_day <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_pend     <= n_pend;
            r_last_day <= n_last_day;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_fail      <= n_fail;
        r_smp_ok    <= n_smp_ok;
        r_smp_addr  <= n_smp_addr;
        r_smp_temp  <= n_smp_temp;
        r_smp_begin <= n_smp_begin;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_n         = r_n;
        n_pend      = 1'b0;
        n_fail      = r_fail;
        n_last_day  = r_last_day;
        n_smp_ok    = r_smp_ok;
        n_smp_addr  = r_smp_addr;
        n_smp_temp  = r_smp_temp;
        n_smp_begin = r_smp_begin;
        n_res       = r_res;
        n_out_vld   = r_out_vld && !i_out_ready;
        n_out       = r_out;
        o_in_ready  = 1'b0;
        o_rd_addr   = ch13[AW-1:0];
        o_wr_en     = 1'b0;
        o_wr_addr   = r_smp_addr;
        o_wr_data   = upd;

        unique case (r_state)
            ST_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx[AW-1:0];
                o_wr_data = '0;
                if (r_idx == CW'(MAX_CHANNELS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    if (i_in_word.mode == MODE_SAMPLE) begin
                        n_smp_ok    = i_in_word.warmup_active && (ch13 < n13);
                        n_smp_addr  = ch13[AW-1:0];
                        n_smp_temp  = i_in_word.temperature;
                        n_smp_begin = i_in_word.begin_day;
                        if (i_in_word.warmup_active) begin
                            n_last_day = i_in_word.day_number;
                        end
                        n_state = ST_SAMPLE;
                    end else if (r_last_day >= i_cfg.max_warmup_days) begin
                        n_res.outcome      = OUTCOME_LIMIT;
                        n_res.restored_day = '0;
                        n_state            = ST_DONE;
                    end else begin
                        n_idx   = '0;
                        n_n     = n13[CW-1:0];
                        n_fail  = 1'b0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SAMPLE: begin
                o_wr_en = r_smp_ok;
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                o_rd_addr = r_idx[AW-1:0];
                if (issue) begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    n_fail = r_fail || !ok_max || !ok_min;
                end
                if (!issue && !r_pend) begin
                    if (r_fail) begin
                        n_res.outcome      = OUTCOME_CONTINUE;
                        n_res.restored_day = r_last_day;
                    end else begin
                        n_res.outcome      = OUTCOME_CONVERGED;
                        n_res.restored_day = '0;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    `DCC_ASSERT_NXT(a_sample_to_rmw, in_acc && (i_in_word.mode == MODE_SAMPLE), r_state == ST_SAMPLE, "sample word did not enter read-modify-write")
    `DCC_ASSERT_IMP(a_scan_no_write, r_state == ST_SCAN, !o_wr_en, "store written during channel scan")
    `DCC_ASSERT_IMP(a_scan_idx_bound, r_state == ST_SCAN, r_idx <= r_n, "scan index ran past channel count")
    `DCC_ASSERT_IMP(a_restored_zero, r_out_vld && (r_out.outcome != OUTCOME_CONTINUE), r_out.restored_day == 12'd0, "restored day set outside continue outcome")

endmodule

FILE: src/daily_extrema_convergence_check_top.sv
// Top level of the daily extrema convergence check
// Sample word: channel entry read, then written back before the next word is accepted.
// Check word: result in o_out_word after a scan of the N channels in use (one store read
//   per cycle, N = channel_count capped at MAX_CHANNELS); day-limit checks skip the scan.
// Reset: registers return to defaults, then a clear pass over all MAX_CHANNELS entries
//   zeroes the extrema store; no word is accepted during that pass, APB writes still are.
module daily_extrema_convergence_check_top #(
    parameter int MAX_CHANNELS = dcc_pkg::MAX_CHANNELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  dcc_pkg::t_in_word            i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output dcc_pkg::t_out_word           o_out_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dcc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dcc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dcc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import dcc_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW = $clog2(MAX_CHANNELS + 1);

    t_cfg          cfg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    t_entry        rd_data;
    t_entry        wr_data;

    assign pready = 1'b1;

    dcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    dcc_ram #(
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dcc_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

endmodule

FILE: tb/sv/daily_extrema_convergence_check_top_tb.sv
// Self-checking testbench for the daily extrema convergence check top level
module daily_extrema_convergence_check_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dcc_pkg::*;

    localparam int NCH            = MAX_CHANNELS_DEF;
    localparam int WORD_TARGET    = 1600;
    localparam int CALM_AFTER     = 1400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = NCH + 40;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_AFTER     = 60;
    localparam int HOLD_CYCLES    = 400;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_word            i_in_word   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_word           o_out_word;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    daily_extrema_convergence_check_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // model of the extrema store and registers
    logic signed [15:0] cur_hi  [NCH];
    logic signed [15:0] cur_lo  [NCH];
    logic signed [15:0] prev_hi [NCH];
    logic signed [15:0] prev_lo [NCH];
    logic [11:0]        rec_day;
    logic [15:0]        tol_m;
    logic [11:0]        wdays_m;
    logic [8:0]         nchan_m;

    t_in_word  word_feed_q [$];
    t_out_word outcome_due_q [$];
    t_out_word due;

    int feed_idle_pct = 0;
    int sink_idle_pct = 0;
    int feed_gap      = 0;
    int sink_gap      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int results_seen  = 0;
    int quiet_cycles  = 0;
    int fails         = 0;
    int words_queued  = 0;
    int day_ctr       = 0;
    int base_t [8];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit near(logic signed [15:0] now_v, logic signed [15:0] old_v);
        int d;
        d = int'(now_v) - int'(old_v);
        if (d < 0) d = -d;
        return d <= int'(tol_m);
    endfunction

    function automatic void predict_outcome(t_in_word w);
        t_out_word r;
        int n;
        bit miss;
        logic signed [15:0] t;
        t = $signed(w.temperature);
        if (w.mode == MODE_SAMPLE) begin
            if (!w.warmup_active) return;
            rec_day = w.day_number;
            if ({1'b0, w.channel} >= nchan_m) return;
            if (w.begin_day) begin
                prev_hi[w.channel] = cur_hi[w.channel];
                prev_lo[w.channel] = cur_lo[w.channel];
                cur_hi[w.channel]  = t;
                cur_lo[w.channel]  = t;
            end else begin
                if (t > cur_hi[w.channel]) cur_hi[w.channel] = t;
                if (t < cur_lo[w.channel]) cur_lo[w.channel] = t;
            end
            return;
        end
        if (rec_day >= wdays_m) begin
            r.outcome      = OUTCOME_LIMIT;
            r.restored_day = '0;
        end else begin
            n = (nchan_m > NCH) ? NCH : int'(nchan_m);
            miss = 1'b0;
            for (int i = 0; i < n && !miss; i++) begin
                if (!near(cur_hi[i], prev_hi[i]) || !near(cur_lo[i], prev_lo[i])) miss = 1'b1;
            end
            if (miss) begin
                r.outcome      = OUTCOME_CONTINUE;
                r.restored_day = rec_day;
            end else begin
                r.outcome      = OUTCOME_CONVERGED;
                r.restored_day = '0;
            end
        end
        outcome_due_q.push_back(r);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            feed_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) predict_outcome(i_in_word);
            if (i_in_valid && !o_in_ready) begin
            end else if (feed_gap > 0) begin
                feed_gap--;
                i_in_valid <= 1'b0;
            end else if (word_feed_q.size() > 0 && feed_idle_pct > 0 &&
                         $urandom_range(0, 99) < feed_idle_pct) begin
                feed_gap = $urandom_range(0, 3);
                i_in_valid <= 1'b0;
            end else if (word_feed_q.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_word  <= word_feed_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (outcome_due_q.size() == 0) begin
                    $error("unexpected word: outcome %0d restored_day %0d",
                           o_out_word.outcome, o_out_word.restored_day);
                    fails++;
                end else begin
                    due = outcome_due_q.pop_front();
                    if (o_out_word.outcome !== due.outcome) begin
                        $error("outcome mismatch: expected %0d, got %0d",
                               due.outcome, o_out_word.outcome);
                        fails++;
                    end
                    if (o_out_word.restored_day !== due.restored_day) begin
                        $error("restored_day mismatch: expected %0d, got %0d",
                               due.restored_day, o_out_word.restored_day);
                        fails++;
                    end
                end
            end
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_out_ready <= 1'b0;
            end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                sink_gap = $urandom_range(0, 3);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (word_feed_q.size() == 0 && !i_in_valid && outcome_due_q.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("daily_extrema_convergence_check_top_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TOLERANCE:     tol_m   = val[15:0];
            REG_MAX_WARMUP:    wdays_m = val[11:0];
            REG_CHANNEL_COUNT: nchan_m = val[8:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        while (word_feed_q.size() > 0 || i_in_valid || outcome_due_q.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic int spread_rand(int a);
        return int'($urandom_range(0, 2 * a)) - a;
    endfunction

    task automatic push_sample(input int ch, input int t, input bit bd, input bit wa,
                               input int day);
        t_in_word w;
        w.mode          = MODE_SAMPLE;
        w.channel       = ch[7:0];
        w.temperature   = clamp16(t);
        w.begin_day     = bd;
        w.warmup_active = wa;
        w.day_number    = day[11:0];
        word_feed_q.push_back(w);
        if (wa) words_queued++;
    endtask

    task automatic push_check();
        t_in_word w;
        logic [63:0] r;
        r = {$urandom, $urandom};
        w = r[$bits(t_in_word)-1:0];
        w.mode = MODE_CHECK;
        word_feed_q.push_back(w);
        words_queued++;
    endtask

    task automatic push_noise();
        t_in_word w;
        logic [63:0] r;
        r = {$urandom, $urandom};
        w = r[$bits(t_in_word)-1:0];
        word_feed_q.push_back(w);
        if (w.mode == MODE_CHECK || w.warmup_active) words_queued++;
    endtask

    // days over the first k channels, with occasional inactive samples and noise words, each closed by a check
    task automatic push_days(input int days, input int k, input int tol_hint);
        int extra;
        int spread;
        for (int d = 0; d < days; d++) begin
            spread = $urandom_range(0, tol_hint / 2 + 1);
            for (int c = 0; c < k; c++) begin
                if ($urandom_range(0, 3) == 0)
                    base_t[c] = base_t[c] + spread_rand(4 * tol_hint + 50);
                else
                    base_t[c] = base_t[c] + spread_rand(tol_hint / 2);
                push_sample(c, base_t[c] + spread_rand(spread), 1'b1, 1'b1, day_ctr);
                extra = $urandom_range(0, 3);
                for (int e = 0; e < extra; e++)
                    push_sample(c, base_t[c] + spread_rand(spread), 1'b0, 1'b1, day_ctr);
                if ($urandom_range(0, 7) == 0)
                    push_sample(c, int'($urandom), 1'($urandom), 1'b0, int'($urandom));
            end
            if ($urandom_range(0, 4) == 0) push_noise();
            push_check();
            day_ctr++;
        end
    endtask

    initial begin
        int tol_v, wdays_v, nchan_v, eff, k, pick;
        for (int i = 0; i < NCH; i++) begin
            cur_hi[i]  = '0;
            cur_lo[i]  = '0;
            prev_hi[i] = '0;
            prev_lo[i] = '0;
        end
        rec_day = '0;
        tol_m   = TOLERANCE_RST;
        wdays_m = MAX_WARMUP_RST;
        nchan_m = CHANNEL_COUNT_RST;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        feed_idle_pct = 25;
        sink_idle_pct = 25;
        push_check();
        push_sample(0, 100, 1'b1, 1'b0, 7);
        push_check();
        push_sample(0, 32767, 1'b1, 1'b1, 3);
        push_sample(0, -32768, 1'b0, 1'b1, 3);
        push_sample(255, -32768, 1'b1, 1'b1, 4);
        push_sample(255, 32767, 1'b0, 1'b1, 4);
        push_check();
        push_sample(1, 5, 1'b1, 1'b1, 25);
        push_check();
        settle();

        write_reg(REG_TOLERANCE, 32'd65535);
        write_reg(REG_MAX_WARMUP, 32'd0);
        write_reg(REG_CHANNEL_COUNT, 32'd1);
        @(negedge i_clk);
        push_sample(0, -1, 1'b0, 1'b1, 0);
        push_check();
        settle();

        write_reg(REG_MAX_WARMUP, 32'd4095);
        @(negedge i_clk);
        push_sample(9, 123, 1'b1, 1'b1, 4094);
        push_check();
        push_sample(0, 0, 1'b1, 1'b1, 4095);
        push_check();
        settle();

        write_reg(REG_CHANNEL_COUNT, 32'd0);
        write_reg(REG_TOLERANCE, 32'd0);
        @(negedge i_clk);
        push_sample(3, 0, 1'b1, 1'b1, 100);
        push_check();
        settle();

        write_reg(REG_CHANNEL_COUNT, 32'd511);
        @(negedge i_clk);
        push_check();
        settle();

        while (words_queued < WORD_TARGET) begin
            pick = $urandom_range(0, 5);
            tol_v = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 100);
            pick = $urandom_range(0, 11);
            wdays_v = (pick == 0) ? 0 : (pick == 1) ? 4095 : (pick == 2) ? 1 :
                      $urandom_range(4, 40);
            pick = $urandom_range(0, 9);
            nchan_v = (pick == 0) ? 256 : (pick == 1) ? 0 :
                      (pick == 2) ? $urandom_range(257, 511) : $urandom_range(1, 8);
            write_reg(REG_TOLERANCE, tol_v);
            write_reg(REG_MAX_WARMUP, wdays_v);
            write_reg(REG_CHANNEL_COUNT, nchan_v);
            @(negedge i_clk);

            if (words_queued >= CALM_AFTER) begin
                feed_idle_pct = 0;
                sink_idle_pct = 0;
            end else begin
                feed_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                sink_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            end

            eff = (nchan_v > NCH) ? NCH : nchan_v;
            k = (eff == 0) ? $urandom_range(1, 3) : ((eff > 6) ? 6 : eff);
            for (int c = 0; c < 8; c++) base_t[c] = spread_rand(30000);
            day_ctr = ($urandom_range(0, 7) == 0) ? $urandom_range(4080, 4095) :
                      $urandom_range(0, 10);
            push_days($urandom_range(4, 10), k, (tol_v > 200) ? 200 : tol_v);
            repeat ($urandom_range(2, 8)) push_noise();
            settle();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fails == 0 && outcome_due_q.size() == 0)
            $display("daily_extrema_convergence_check_top_tb: done, clean");
        else
            $display("daily_extrema_convergence_check_top_tb: done, errors");
        $finish;
    end

endmodule
